### rtl/sswr_pkg.sv
package sswr_pkg;

    localparam logic [30:0] ONE_Q30       = 31'd1073741824;
    localparam logic [31:0] PI_Q30        = 32'd3373259426;
    localparam logic [29:0] TURNS_PER_RAD = 30'd683565276;
    localparam logic [63:0] QUARTER_TURN  = 64'h0000_0000_4000_0000;

    // Reciprocal scale for exact constant division: floor(p / d) == (p * ceil(2^37 / d)) >> 37
    // for every p below 2^30.
    localparam int          RECIP_SHIFT = 37;
    localparam logic [63:0] RECIP_NUM   = 64'd137438953472;

    localparam logic [36:0] SIN_R0 = 37'((RECIP_NUM + 64'd71) / 64'd72);
    localparam logic [36:0] SIN_R1 = 37'((RECIP_NUM + 64'd41) / 64'd42);
    localparam logic [36:0] SIN_R2 = 37'((RECIP_NUM + 64'd19) / 64'd20);
    localparam logic [36:0] SIN_R3 = 37'((RECIP_NUM + 64'd5) / 64'd6);
    localparam logic [36:0] COS_R0 = 37'((RECIP_NUM + 64'd89) / 64'd90);
    localparam logic [36:0] COS_R1 = 37'((RECIP_NUM + 64'd55) / 64'd56);
    localparam logic [36:0] COS_R2 = 37'((RECIP_NUM + 64'd29) / 64'd30);
    localparam logic [36:0] COS_R3 = 37'((RECIP_NUM + 64'd11) / 64'd12);
    localparam logic [36:0] COS_R4 = 37'((RECIP_NUM + 64'd1) / 64'd2);

    // Horner steps per lane, and lane depth: angle, square, two per step, select, square
    localparam int HORNER_STEPS = 5;
    localparam int LANE_DEPTH   = 2 * HORNER_STEPS + 4;

    typedef struct packed {
        logic [30:0] sin_sq;
        logic [30:0] cos_mag;
        logic        cos_neg;
    } t_trig;

    function automatic logic [36:0] sin_recip(input logic [2:0] k);
        case (k)
            3'd0:    return SIN_R0;
            3'd1:    return SIN_R1;
            3'd2:    return SIN_R2;
            3'd3:    return SIN_R3;
            default: return '0;
        endcase
    endfunction

    function automatic logic [36:0] cos_recip(input logic [2:0] k);
        case (k)
            3'd0:    return COS_R0;
            3'd1:    return COS_R1;
            3'd2:    return COS_R2;
            3'd3:    return COS_R3;
            3'd4:    return COS_R4;
            default: return '0;
        endcase
    endfunction

endpackage

### rtl/sswr_if.sv
interface sswr_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        ra_first;
    logic signed [30:0] dec_first;
    logic [31:0]        ra_second;
    logic signed [30:0] dec_second;

    modport source (output valid, ra_first, dec_first, ra_second, dec_second, input ready);
    modport sink   (input valid, ra_first, dec_first, ra_second, dec_second, output ready);
endinterface

interface sswr_out_if;
    logic        valid;
    logic        ready;
    logic        is_close;
    logic [30:0] hav_term;

    modport source (output valid, is_close, hav_term, input ready);
    modport sink   (input valid, is_close, hav_term, output ready);
endinterface

### rtl/sswr_trig_lane.sv
module sswr_trig_lane
    import sswr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_phase,
    output t_trig       o_trig
);

    logic [29:0] r_a0;
    logic [2:0]  r_oct0;
    logic [29:0] r_x2  [0:HORNER_STEPS];
    logic [29:0] r_a   [0:HORNER_STEPS];
    logic [2:0]  r_oct [0:HORNER_STEPS];
    logic [30:0] r_us  [1:HORNER_STEPS];
    logic [30:0] r_uc  [1:HORNER_STEPS];
    logic [29:0] r_m_x2  [0:HORNER_STEPS-1];
    logic [29:0] r_m_a   [0:HORNER_STEPS-1];
    logic [2:0]  r_m_oct [0:HORNER_STEPS-1];
    logic [29:0] r_m_ps  [0:HORNER_STEPS-1];
    logic [29:0] r_m_pc  [0:HORNER_STEPS-1];
    logic [30:0] us_in [0:HORNER_STEPS-1];
    logic [30:0] uc_in [0:HORNER_STEPS-1];

    logic [29:0] fold_r;
    logic [30:0] r_sin_mag;
    logic [30:0] r_cos_mag;
    logic        r_cos_neg;
    logic [30:0] sp;
    logic [30:0] cp;
    logic [30:0] sin_mag;
    logic [30:0] cos_mag;
    t_trig       r_trig;

    // Fold the phase into the first octant
    always_comb begin
        if (i_phase[29]) begin
            fold_r = 30'h2000_0000 - {1'b0, i_phase[28:0]};
        end else begin
            fold_r = {1'b0, i_phase[28:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0     <= 30'((62'(fold_r) * 62'(PI_Q30)) >> 31);
            r_oct0   <= i_phase[31:29];
            r_x2[0]  <= 30'((60'(r_a0) * 60'(r_a0)) >> 30);
            r_a[0]   <= r_a0;
            r_oct[0] <= r_oct0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < HORNER_STEPS; k++) begin : g_step
            if (k == 0) begin : g_first
                assign us_in[k] = ONE_Q30;
                assign uc_in[k] = ONE_Q30;
            end else begin : g_rest
                assign us_in[k] = r_us[k];
                assign uc_in[k] = r_uc[k];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_m_x2[k]  <= r_x2[k];
                    r_m_a[k]   <= r_a[k];
                    r_m_oct[k] <= r_oct[k];
                    r_m_pc[k]  <= 30'((61'(r_x2[k]) * 61'(uc_in[k])) >> 30);
                    r_x2[k+1]  <= r_m_x2[k];
                    r_a[k+1]   <= r_m_a[k];
                    r_oct[k+1] <= r_m_oct[k];
                    r_uc[k+1]  <= ONE_Q30 - 31'((67'(r_m_pc[k]) * 67'(cos_recip(3'(k))))
                                  >> RECIP_SHIFT);
                end
            end

            if (k < HORNER_STEPS - 1) begin : g_sin
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_m_ps[k] <= 30'((61'(r_x2[k]) * 61'(us_in[k])) >> 30);
                        r_us[k+1] <= ONE_Q30 - 31'((67'(r_m_ps[k]) * 67'(sin_recip(3'(k))))
                                     >> RECIP_SHIFT);
                    end
                end
            end else begin : g_sa
                // Last slot: scale the sine series by the angle, then carry it
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_m_ps[k] <= 30'((61'(r_a[k]) * 61'(us_in[k])) >> 30);
                        r_us[k+1] <= {1'b0, r_m_ps[k]};
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        if (r_oct[HORNER_STEPS][0]) begin
            sp = r_uc[HORNER_STEPS];
            cp = r_us[HORNER_STEPS];
        end else begin
            sp = r_us[HORNER_STEPS];
            cp = r_uc[HORNER_STEPS];
        end
        sin_mag = r_oct[HORNER_STEPS][1] ? cp : sp;
        cos_mag = r_oct[HORNER_STEPS][1] ? sp : cp;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_mag <= sin_mag;
            r_cos_mag <= cos_mag;
            // Second and third quadrants carry a negative cosine; zero stays positive
            r_cos_neg <= (r_oct[HORNER_STEPS][2] ^ r_oct[HORNER_STEPS][1]) && (cos_mag != '0);
            r_trig.sin_sq  <= 31'((62'(r_sin_mag) * 62'(r_sin_mag)) >> 30);
            r_trig.cos_mag <= r_cos_mag;
            r_trig.cos_neg <= r_cos_neg;
        end
    end

    assign o_trig = r_trig;

endmodule

### rtl/sky_separation_within_radius_core.sv
// Sky separation test: each transfer on i_in carries two sky positions (RA and Dec in
// fixed-point radians); the block returns the haversine term h in unsigned Q1.30, saturated
// to [0, 1.0], and is_close, set when the angular distance is strictly below the match radius
// (decided as h < sin^2(radius/2), or always when the radius exceeds pi). The pipeline takes
// one pair every clock; results pass through the phase registers, the five sine/cosine lanes
// with their Horner multiply stages, and the product, term and output registers. When o_out
// is held not ready with a result waiting, the whole pipeline holds and i_in.ready drops.
// Write i_cfg_wdata while no item is in flight; it applies to transfers from the next edge on.
module sky_separation_within_radius_core
    import sswr_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 29
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sswr_in_if.sink     i_in,
    sswr_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);

    localparam int DEPTH = LANE_DEPTH + 4;
    localparam logic signed [63:0] TURNS_S = 64'(TURNS_PER_RAD);

    logic              en;
    logic [DEPTH-1:0]  r_valid;
    logic [30:0]       r_match_radius;
    logic              r_far;

    logic signed [32:0] dra;
    logic signed [31:0] ddec;
    logic signed [63:0] p_ra;
    logic signed [63:0] p_ddec;
    logic signed [63:0] p_deca;
    logic signed [63:0] p_decb;
    logic [63:0]        p_rad;
    logic [31:0]        r_phase [0:4];
    t_trig              trig    [0:4];

    logic [30:0]  r_cprod;
    logic         r_neg1;
    logic [30:0]  r_sdec1;
    logic [30:0]  r_sra1;
    logic [30:0]  r_thr1;
    logic [30:0]  r_term;
    logic         r_neg2;
    logic [30:0]  r_sdec2;
    logic [30:0]  r_thr2;
    logic signed [32:0] h_raw;
    logic [30:0]  h_sat;
    logic         r_is_close;
    logic [30:0]  r_hav_term;

    assign en          = !r_valid[DEPTH-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_valid[DEPTH-1];
    assign o_out.is_close = r_is_close;
    assign o_out.hav_term = r_hav_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_match_radius <= '0;
        end else begin
            if (en) begin
                r_valid <= {r_valid[DEPTH-2:0], i_in.valid};
            end
            if (i_cfg_we) begin
                r_match_radius <= i_cfg_wdata;
            end
        end
    end

    // Angle to Q32 turns; arithmetic shift gives the floor for negative angles
    always_comb begin
        dra    = $signed({1'b0, i_in.ra_second}) - $signed({1'b0, i_in.ra_first});
        ddec   = 32'(i_in.dec_second) - 32'(i_in.dec_first);
        p_ra   = 64'(dra) * TURNS_S;
        p_ddec = 64'(ddec) * TURNS_S;
        p_deca = 64'(i_in.dec_first) * TURNS_S;
        p_decb = 64'(i_in.dec_second) * TURNS_S;
        p_rad  = (64'(r_match_radius) * 64'(TURNS_PER_RAD)) >> (ANGLE_FRAC_BITS + 1);
    end

    always_ff @(posedge i_clk) begin
        r_far <= p_rad > QUARTER_TURN;
        if (en) begin
            r_phase[0] <= 32'(p_ddec >>> (ANGLE_FRAC_BITS + 1));
            r_phase[1] <= 32'(p_ra >>> (ANGLE_FRAC_BITS + 1));
            r_phase[2] <= 32'(p_deca >>> ANGLE_FRAC_BITS);
            r_phase[3] <= 32'(p_decb >>> ANGLE_FRAC_BITS);
            r_phase[4] <= p_rad[31:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 5; g++) begin : g_lane
            sswr_trig_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_phase (r_phase[g]),
                .o_trig  (trig[g])
            );
        end
    endgenerate

    always_comb begin
        h_raw = $signed({2'b00, r_sdec2}) +
                (r_neg2 ? -$signed({2'b00, r_term}) : $signed({2'b00, r_term}));
        if (h_raw < 0) begin
            h_sat = '0;
        end else if (h_raw > $signed({2'b00, ONE_Q30})) begin
            h_sat = ONE_Q30;
        end else begin
            h_sat = h_raw[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cprod <= 31'((62'(trig[2].cos_mag) * 62'(trig[3].cos_mag)) >> 30);
            r_neg1  <= trig[2].cos_neg ^ trig[3].cos_neg;
            r_sdec1 <= trig[0].sin_sq;
            r_sra1  <= trig[1].sin_sq;
            r_thr1  <= trig[4].sin_sq;

            r_term  <= 31'((62'(r_cprod) * 62'(r_sra1)) >> 30);
            r_neg2  <= r_neg1;
            r_sdec2 <= r_sdec1;
            r_thr2  <= r_thr1;

            r_hav_term <= h_sat;
            r_is_close <= r_far || (h_sat < r_thr2);
        end
    end

endmodule

### rtl/sswr_checker.sv
module sswr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_is_close,
    input logic [30:0] out_hav_term
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_is_close) && $stable(out_hav_term))
        else $error("result changed while stalled");

    a_hav_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_hav_term <= 31'd1073741824)
        else $error("haversine term above one");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while pipeline held");

endmodule

bind sky_separation_within_radius_core sswr_checker u_sswr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_ready     (i_in.ready),
    .out_valid    (o_out.valid),
    .out_ready    (o_out.ready),
    .out_is_close (o_out.is_close),
    .out_hav_term (o_out.hav_term)
);

### tb/sswr_tb_if.sv
`timescale 1ns / 100ps
// Channel interfaces come from the RTL; this file only holds shared scoreboard types.
package sswr_tb_pkg;
    typedef struct packed {
        logic [31:0]        ra_first;
        logic signed [30:0] dec_first;
        logic [31:0]        ra_second;
        logic signed [30:0] dec_second;
    } t_pair;

    typedef struct packed {
        logic        is_close;
        logic [30:0] hav_term;
    } t_match;
endpackage

### tb/sky_separation_within_radius_core_test.sv
`timescale 1ns / 100ps
module sky_separation_within_radius_core_test;
    import sswr_pkg::*;
    import sswr_tb_pkg::*;

    localparam int          FRAC        = 29;
    localparam longint      STEP_LIMIT  = 400000;
    localparam logic [30:0] RADIUS_MAX  = 31'd1686629713;
    localparam logic [31:0] RA_MAX      = 32'd3373259426;
    localparam int          DEC_MAX     = 843314857;
    localparam int          N_RANDOM    = 1430;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;

    sswr_in_if  pair_ch ();
    sswr_out_if match_ch ();

    sky_separation_within_radius_core #(.ANGLE_FRAC_BITS(FRAC)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(pair_ch.sink), .o_out(match_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [30:0] radius_cfg;
    t_match      pending_matches[$];
    int          fail_count = 0;
    longint      cycle_count = 0;

    // Fixed-point model of the sky separation -----------------------------

    function automatic logic [31:0] angle_phase(longint x, int sh);
        logic [63:0] prod;
        prod = 64'(x) * 64'd683565276;
        if (x < 0) return 32'(~((~prod) >> sh));
        return 32'(prod >> sh);
    endfunction

    function automatic logic [63:0] horner_eval(logic [63:0] x2, bit is_cos);
        logic [63:0] acc;
        int n;
        longint divs[5];
        acc = 64'd1073741824;
        if (is_cos) begin
            divs = '{90, 56, 30, 12, 2};
            n = 5;
        end else begin
            divs = '{72, 42, 20, 6, 1};
            n = 4;
        end
        for (int i = 0; i < n; i++)
            acc = 64'd1073741824 - ((x2 * acc) >> 30) / 64'(divs[i]);
        return acc;
    endfunction

    function automatic void phase_sincos(input logic [31:0] q, output longint s,
                                         output longint c);
        logic [2:0]  oct;
        logic [63:0] r, a, x2, sa, ca, sp, cp;
        oct = q[31:29];
        r = 64'(q[28:0]);
        if (oct[0]) r = 64'h2000_0000 - r;
        a = (r * 64'd3373259426) >> 31;
        x2 = (a * a) >> 30;
        sa = (a * horner_eval(x2, 1'b0)) >> 30;
        ca = horner_eval(x2, 1'b1);
        if (oct[0]) begin
            sp = ca; cp = sa;
        end else begin
            sp = sa; cp = ca;
        end
        case (oct[2:1])
            2'd0: begin s = longint'(sp);  c = longint'(cp);  end
            2'd1: begin s = longint'(cp);  c = -longint'(sp); end
            2'd2: begin s = -longint'(sp); c = -longint'(cp); end
            default: begin s = -longint'(cp); c = longint'(sp); end
        endcase
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] phase_sin_sq(logic [31:0] q);
        longint s, c;
        phase_sincos(q, s, c);
        return (abs64(s) * abs64(s)) >> 30;
    endfunction

    function automatic longint phase_cos(logic [31:0] q);
        longint s, c;
        phase_sincos(q, s, c);
        return c;
    endfunction

    function automatic t_match predict_match(t_pair p);
        longint ra_a, ra_b, dec_a, dec_b, ca, cb, h;
        logic [63:0] s_dec, s_ra, cprod, term, rphase;
        t_match m;
        ra_a = longint'(p.ra_first);
        ra_b = longint'(p.ra_second);
        dec_a = longint'(p.dec_first);
        dec_b = longint'(p.dec_second);
        s_dec = phase_sin_sq(angle_phase(dec_b - dec_a, FRAC + 1));
        s_ra = phase_sin_sq(angle_phase(ra_b - ra_a, FRAC + 1));
        ca = phase_cos(angle_phase(dec_a, FRAC));
        cb = phase_cos(angle_phase(dec_b, FRAC));
        cprod = (abs64(ca) * abs64(cb)) >> 30;
        term = (cprod * s_ra) >> 30;
        h = ((ca < 0) != (cb < 0)) ? longint'(s_dec) - longint'(term)
                                   : longint'(s_dec) + longint'(term);
        if (h < 0) h = 0;
        if (h > 1073741824) h = 1073741824;
        rphase = (64'(radius_cfg) * 64'd683565276) >> (FRAC + 1);
        if (rphase > QUARTER_TURN) m.is_close = 1'b1;
        else m.is_close = 64'(h) < phase_sin_sq(32'(rphase));
        m.hav_term = 31'(h);
        return m;
    endfunction

    // Driving ---------------------------------------------------------------

    initial begin
        pair_ch.valid = 1'b0;
        pair_ch.ra_first = '0;
        pair_ch.dec_first = '0;
        pair_ch.ra_second = '0;
        pair_ch.dec_second = '0;
        match_ch.ready = 1'b0;
    end

    task automatic write_radius(input logic [30:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        radius_cfg = value;
        repeat (3) @(posedge i_clk);
    endtask

    // Directed rows carry a typed-in expectation where it is obvious; the
    // rest are left to the predictor.
    typedef struct {
        t_pair  pair;
        bit     has_fixed;
        t_match fixed;
    } t_row;

    task automatic send_pair(input t_pair p, input bit has_fixed, input t_match fixed);
        t_match m;
        int     gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        m = predict_match(p);
        if (has_fixed && m != fixed) begin
            $display("%0t table row disagrees: expected %h, predicted %h", $time, fixed, m);
            fail_count++;
        end
        pending_matches.push_back(has_fixed ? fixed : m);
        pair_ch.valid <= 1'b1;
        {pair_ch.ra_first, pair_ch.dec_first, pair_ch.ra_second, pair_ch.dec_second} <= p;
        do @(posedge i_clk); while (!pair_ch.ready);
    endtask

    task automatic drain_matches();
        pair_ch.valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    function automatic t_pair random_pair(int mode);
        t_pair p;
        p.ra_first = 32'($urandom_range(0, RA_MAX));
        p.dec_first = 31'($urandom_range(0, 2 * DEC_MAX) - DEC_MAX);
        case (mode)
            0: begin
                // near neighbors, where the radius test is decided
                p.ra_second = p.ra_first + 32'($urandom_range(0, 2000000) - 1000000);
                p.dec_second = p.dec_first + 31'($urandom_range(0, 2000000) - 1000000);
            end
            1: begin
                p.ra_second = 32'($urandom_range(0, RA_MAX));
                p.dec_second = 31'($urandom_range(0, 2 * DEC_MAX) - DEC_MAX);
            end
            default: begin
                // any bit pattern, including wrapped angles
                p.ra_first = $urandom;
                p.dec_first = 31'($urandom);
                p.ra_second = $urandom;
                p.dec_second = 31'($urandom);
            end
        endcase
        return p;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        logic [30:0] radii[6];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        radius_cfg = '0;

        // identical points give h = 0; zero radius never matches
        row.pair = '{32'd0, 31'sd0, 32'd0, 31'sd0};
        row.has_fixed = 1'b1;
        row.fixed = '{1'b0, 31'd0};
        rows.push_back(row);
        row.has_fixed = 1'b0;
        row.pair = '{RA_MAX, 31'(DEC_MAX), RA_MAX, 31'(DEC_MAX)}; rows.push_back(row);
        row.pair = '{32'd0, 31'(-DEC_MAX), 32'd0, 31'(DEC_MAX)}; rows.push_back(row);
        row.pair = '{32'd0, 31'sd0, RA_MAX, 31'sd0}; rows.push_back(row);
        row.pair = '{32'd0, 31'sd0, 32'd1686629713, 31'sd0}; rows.push_back(row);
        row.pair = '{RA_MAX, 31'(-DEC_MAX), 32'd0, 31'(DEC_MAX)}; rows.push_back(row);
        row.pair = '{32'hFFFF_FFFF, 31'h3FFF_FFFF, 32'd0, 31'h4000_0000}; rows.push_back(row);
        row.pair = '{32'd0, 31'h4000_0000, 32'hFFFF_FFFF, 31'h4000_0000}; rows.push_back(row);
        row.pair = '{32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000};
        rows.push_back(row);
        row.pair = '{32'd12345, 31'sd1000, 32'd12346, 31'sd1001}; rows.push_back(row);

        radii = '{RADIUS_MAX, 31'd0, 31'h7FFF_FFFF, 31'd1686629714, 31'd5000000, 31'd300000};
        foreach (radii[k]) begin
            write_radius(radii[k]);
            foreach (rows[j]) send_pair(rows[j].pair, rows[j].has_fixed && k == 1, rows[j].fixed);
            drain_matches();
        end

        foreach (radii[k]) begin
            write_radius(k % 2 ? 31'($urandom_range(0, RADIUS_MAX)) : radii[k]);
            for (int n = 0; n < N_RANDOM / 6; n++)
                send_pair(random_pair(n % 10 < 6 ? 0 : (n % 10 < 9 ? 1 : 2)), 1'b0, '0);
            drain_matches();
        end

        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, compare against the oldest expectation.
    initial begin
        t_match want;
        int     gap;
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                match_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            match_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!match_ch.valid);
            if (pending_matches.size() == 0) begin
                $display("%0t unexpected transfer: got %b %h", $time,
                         match_ch.is_close, match_ch.hav_term);
                fail_count++;
            end else begin
                want = pending_matches.pop_front();
                if (match_ch.is_close !== want.is_close) begin
                    $display("%0t is_close: expected %b, got %b", $time,
                             want.is_close, match_ch.is_close);
                    fail_count++;
                end
                if (match_ch.hav_term !== want.hav_term) begin
                    $display("%0t hav_term: expected %h, got %h", $time,
                             want.hav_term, match_ch.hav_term);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > STEP_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end
endmodule
